// ===== hdl/qau_pkg.sv =====
package qau_pkg;

  localparam int WORD_BITS = 24;

  typedef enum logic [2:0] {
    ACT_ADD     = 3'd0,
    ACT_PRODUCT = 3'd1,
    ACT_SCALE   = 3'd2,
    ACT_CONJ    = 3'd3,
    ACT_DIFF    = 3'd4,
    ACT_DOT     = 3'd5,
    ACT_MATRIX  = 3'd6
  } action_t;

  typedef struct packed {
    logic [2:0]                  action;
    logic signed [WORD_BITS-1:0] a_w;
    logic signed [WORD_BITS-1:0] a_x;
    logic signed [WORD_BITS-1:0] a_y;
    logic signed [WORD_BITS-1:0] a_z;
    logic signed [WORD_BITS-1:0] b_w;
    logic signed [WORD_BITS-1:0] b_x;
    logic signed [WORD_BITS-1:0] b_y;
    logic signed [WORD_BITS-1:0] b_z;
  } qau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] r_w;
    logic signed [WORD_BITS-1:0] r_x;
    logic signed [WORD_BITS-1:0] r_y;
    logic signed [WORD_BITS-1:0] r_z;
    logic                        last;
  } qau_out_t;

endpackage

// ===== hdl/quaternion_arithmetic_unit_core.sv =====
// an accepted input beat passes the input register, the rounded-product register
// and the result register on its way to its first result beat
// throughput: one item per cycle while out_stall is low; a rotation matrix item
// gives one row per cycle, its rows leaving one at a time through the result register
// reset: synchronous, active low; clears the valid flags and the row counter
module quaternion_arithmetic_unit_core #(
  parameter int FRAC_BITS = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  qau_pkg::qau_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output qau_pkg::qau_out_t out_data
);
  import qau_pkg::*;

  localparam int OPW = WORD_BITS + 1;
  localparam int MW  = 2 * OPW;
  localparam int PW  = MW - FRAC_BITS;
  localparam int SW  = ((PW > FRAC_BITS + 1) ? PW : FRAC_BITS + 1) + 3;
  localparam int NPROD = 16;

  localparam logic signed [MW-1:0] HALF   = MW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] ONE_Q  = SW'(1) << FRAC_BITS;
  localparam logic signed [SW-1:0] SAT_HI = SW'((2 ** (WORD_BITS - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;
  localparam logic [1:0]           ROW_LAST = 2'd2;

  function automatic logic signed [WORD_BITS-1:0] sat_word(input logic signed [SW-1:0] v);
    if (v > SAT_HI) begin
      return SAT_HI[WORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      return SAT_LO[WORD_BITS-1:0];
    end else begin
      return v[WORD_BITS-1:0];
    end
  endfunction

  // handshake
  logic out_valid_r, out_valid_nxt;
  logic s1_valid_r, s1_valid_nxt;
  logic s2_valid_r, s2_valid_nxt;
  logic [1:0] row_r, row_nxt;
  logic out_free, emit, s2_done, s2_free, s1_move, accept;

  // payload
  qau_in_t  s1_r;
  qau_out_t out_r, out_nxt;
  logic [2:0] s2_act_r;
  logic signed [WORD_BITS-1:0] s2_a_r [4];
  logic signed [WORD_BITS-1:0] s2_b_r [4];
  logic signed [PW-1:0]        s2_p_r [NPROD];

  logic signed [WORD_BITS-1:0] s1_a [4];
  logic signed [WORD_BITS-1:0] s1_b [4];
  logic signed [OPW-1:0]       a_op [4];
  logic signed [OPW-1:0]       b_op [4];
  logic signed [MW-1:0]        prod_full [NPROD];
  logic signed [MW-1:0]        prod_rnd  [NPROD];

  logic signed [SW-1:0] e  [NPROD];
  logic signed [SW-1:0] wa [4];
  logic signed [SW-1:0] wb [4];
  logic signed [SW-1:0] r_w_s, r_x_s, r_y_s, r_z_s;
  logic last_s;

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = s2_valid_r && out_free;
  assign s2_done  = emit && ((s2_act_r != ACT_MATRIX) || (row_r == ROW_LAST));
  assign s2_free  = !s2_valid_r || s2_done;
  assign s1_move  = s1_valid_r && s2_free;
  assign in_stall = s1_valid_r && !s2_free;
  assign accept   = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    s2_valid_nxt = s2_valid_r;
    if (s1_move) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_done) begin
      s2_valid_nxt = 1'b0;
    end
    row_nxt = row_r;
    if (s2_done) begin
      row_nxt = '0;
    end else if (emit) begin
      row_nxt = row_r + 2'd1;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
    end
  end

  // stage 1: operand select and the sixteen rounded products
  assign s1_a[0] = s1_r.a_w;
  assign s1_a[1] = s1_r.a_x;
  assign s1_a[2] = s1_r.a_y;
  assign s1_a[3] = s1_r.a_z;
  assign s1_b[0] = s1_r.b_w;
  assign s1_b[1] = s1_r.b_x;
  assign s1_b[2] = s1_r.b_y;
  assign s1_b[3] = s1_r.b_z;

  // matrix reuses the product slots with b = a; difference negates b's vector at full width
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      a_op[i] = {s1_a[i][WORD_BITS-1], s1_a[i]};
      if (s1_r.action == ACT_MATRIX) begin
        b_op[i] = {s1_a[i][WORD_BITS-1], s1_a[i]};
      end else if ((s1_r.action == ACT_DIFF) && (i != 0)) begin
        b_op[i] = -{s1_b[i][WORD_BITS-1], s1_b[i]};
      end else begin
        b_op[i] = {s1_b[i][WORD_BITS-1], s1_b[i]};
      end
    end
  end

  // slot k multiplies a[k%4] by b[(k%4) ^ (k/4)]
  for (genvar k = 0; k < NPROD; k++) begin : g_prod
    localparam int AI = k % 4;
    localparam int BI = (k % 4) ^ (k / 4);
    assign prod_full[k] = a_op[AI] * b_op[BI];
    assign prod_rnd[k]  = (prod_full[k] + HALF) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= in_data;
    end
    if (s1_move) begin
      s2_act_r <= s1_r.action;
      for (int i = 0; i < 4; i++) begin
        s2_a_r[i] <= s1_a[i];
        s2_b_r[i] <= s1_b[i];
      end
      for (int k = 0; k < NPROD; k++) begin
        s2_p_r[k] <= prod_rnd[k][PW-1:0];
      end
    end
    if (emit) begin
      out_r <= out_nxt;
    end
  end

  // stage 2: sums, row select and saturation
  for (genvar k = 0; k < NPROD; k++) begin : g_ext
    assign e[k] = {{(SW-PW){s2_p_r[k][PW-1]}}, s2_p_r[k]};
  end

  for (genvar i = 0; i < 4; i++) begin : g_word
    assign wa[i] = {{(SW-WORD_BITS){s2_a_r[i][WORD_BITS-1]}}, s2_a_r[i]};
    assign wb[i] = {{(SW-WORD_BITS){s2_b_r[i][WORD_BITS-1]}}, s2_b_r[i]};
  end

  always_comb begin
    r_w_s  = '0;
    r_x_s  = '0;
    r_y_s  = '0;
    r_z_s  = '0;
    last_s = 1'b1;
    unique case (s2_act_r)
      ACT_ADD: begin
        r_w_s = wa[0] + wb[0];
        r_x_s = wa[1] + wb[1];
        r_y_s = wa[2] + wb[2];
        r_z_s = wa[3] + wb[3];
      end
      ACT_PRODUCT, ACT_DIFF: begin
        r_w_s = e[0] - e[1] - e[2] - e[3];
        r_x_s = e[4] + e[5] + e[6] - e[7];
        r_y_s = e[8] - e[9] + e[10] + e[11];
        r_z_s = e[12] + e[13] - e[14] + e[15];
      end
      ACT_SCALE: begin
        r_w_s = e[0];
        r_x_s = e[5];
        r_y_s = e[10];
        r_z_s = e[15];
      end
      ACT_CONJ: begin
        r_w_s = wa[0];
        r_x_s = -wa[1];
        r_y_s = -wa[2];
        r_z_s = -wa[3];
      end
      ACT_DOT: begin
        r_w_s = e[0] + e[1] + e[2] + e[3];
      end
      ACT_MATRIX: begin
        // xx=e1 yy=e2 zz=e3 xw=e4 yz=e6 yw=e8 xz=e9 zw=e12 xy=e13
        last_s = (row_r == ROW_LAST);
        unique case (row_r)
          2'd0: begin
            r_x_s = ONE_Q - ((e[2] + e[3]) <<< 1);
            r_y_s = (e[13] - e[12]) <<< 1;
            r_z_s = (e[9] + e[8]) <<< 1;
          end
          2'd1: begin
            r_x_s = (e[13] + e[12]) <<< 1;
            r_y_s = ONE_Q - ((e[1] + e[3]) <<< 1);
            r_z_s = (e[6] - e[4]) <<< 1;
          end
          default: begin
            r_x_s = (e[9] - e[8]) <<< 1;
            r_y_s = (e[6] + e[4]) <<< 1;
            r_z_s = ONE_Q - ((e[1] + e[2]) <<< 1);
          end
        endcase
      end
      default: begin
        last_s = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_nxt.r_w  = sat_word(r_w_s);
    out_nxt.r_x  = sat_word(r_x_s);
    out_nxt.r_y  = sat_word(r_y_s);
    out_nxt.r_z  = sat_word(r_z_s);
    out_nxt.last = last_s;
  end

  a_row_only_matrix: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r != 2'd0) |-> (s2_valid_r && (s2_act_r == ACT_MATRIX)))
    else $error("row counter running outside a matrix item");

  a_matrix_last: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (s2_act_r == ACT_MATRIX)) |-> (out_nxt.last == (row_r == ROW_LAST)))
    else $error("matrix last flag on wrong row");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("emitted beat not presented");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && !s2_done))
    else $error("input stalled with room in the pipeline");

endmodule
